// ===== sv/dmc_pkg.sv =====
package dmc_pkg;

   // Geometry of the modeled memory system; all sizes are powers of two.
   localparam int ADDR_BITS   = 16;
   localparam int LINE_BITS   = 4;   // log2 of words per cache line (16)
   localparam int INDEX_BITS  = 6;   // log2 of cache lines (64)
   localparam int BUF_BITS    = 6;   // log2 of words in the DRAM buffer (64)
   localparam int LINES       = 1 << INDEX_BITS;
   localparam int CTAG_BITS   = ADDR_BITS - LINE_BITS - INDEX_BITS;
   localparam int BTAG_BITS   = ADDR_BITS - BUF_BITS;

   localparam logic [ADDR_BITS:0] ADDR_SPACE = 17'd65536;

   localparam int CYC_BITS = 13;
   localparam int SUM_BITS = CYC_BITS + 1;
   localparam logic [CYC_BITS-1:0] CYCLES_MAX = 13'd8191;
   localparam logic [CYC_BITS-1:0] HIT_CYCLES = 13'd1;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 10;

   typedef enum logic {
      CMD_ACCESS = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_LATENCY  = 2'd1,
      CSR_UPDATE   = 2'd2,
      CSR_PER_WORD = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic                hit;
      logic [CYC_BITS-1:0] cycles;
      logic                range_error;
   } rsp_type;

endpackage

// ===== sv/direct_mapped_cache_timing_model.sv =====
// Channel  | Ports                        | Payload (low bit up)
// ---------+------------------------------+--------------------------------------
// request  | req_tvalid/tready/tdata/tuser| tdata: address[15:0]; tuser: command
// response | rsp_tvalid/tready/tdata      | tdata: hit, cycles[12:0], range_error, 0
// csr      | csr_we/csr_index/csr_wdata   | wdata: register value, low bits used
//
// One word per cycle sustained while responses are taken. An accepted request
// reads the tag RAM as it enters the compare stage, which then compares, writes
// back and loads the response register. A tag written there is forwarded to a
// same-line request accepted alongside the write. Reset is synchronous and
// empties the pipeline and all tag valid bits. A stalled response holds the
// compare stage, which in turn drops req_tready.
module direct_mapped_cache_timing_model
   import dmc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ADDR_BITS-1:0]     req_tdata,   // address[15:0]
   input  logic                     req_tuser,   // command
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // hit, cycles[12:0], range_error, pad
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // configuration registers
   logic       enable_ff;
   logic [9:0] latency_ff;
   logic [7:0] update_ff;
   logic [5:0] per_word_ff;

   // tag storage: tags in RAM, valid bits in flops
   logic [CTAG_BITS-1:0] tag_mem [LINES];
   logic [CTAG_BITS-1:0] tag_rd_ff;
   logic [LINES-1:0]     line_valid_ff, line_valid_in;
   logic                 buf_valid_ff, buf_valid_in;
   logic [BTAG_BITS-1:0] buf_tag_ff, buf_tag_in;

   // compare stage
   logic                 s1_valid_ff, s1_valid_in;
   cmd_type              s1_cmd_ff;
   logic [ADDR_BITS-1:0] s1_addr_ff;
   logic                 fwd_ff;
   logic [CTAG_BITS-1:0] fwd_tag_ff;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic                  s0_adv, s1_go;
   logic [INDEX_BITS-1:0] req_line, s1_line;
   logic [CTAG_BITS-1:0]  s1_ctag, line_tag;
   logic [BTAG_BITS-1:0]  s1_btag;
   logic                  s1_err, cache_hit, buf_hit;
   logic                  cache_fill, buf_fill, tags_clear;
   logic [SUM_BITS-1:0]   miss_sum;
   rsp_type               rsp_in;

   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign s0_adv     = req_tvalid && req_tready;

   assign req_line = req_tdata[LINE_BITS +: INDEX_BITS];
   assign s1_line  = s1_addr_ff[LINE_BITS +: INDEX_BITS];
   assign s1_ctag  = s1_addr_ff[ADDR_BITS-1 -: CTAG_BITS];
   assign s1_btag  = s1_addr_ff[ADDR_BITS-1 -: BTAG_BITS];
   assign s1_err   = {1'b0, s1_addr_ff} >= ADDR_SPACE;

   // the RAM word read alongside a same-line write is stale; use the forwarded tag
   assign line_tag  = fwd_ff ? fwd_tag_ff : tag_rd_ff;
   assign cache_hit = line_valid_ff[s1_line] && (line_tag == s1_ctag);
   assign buf_hit   = buf_valid_ff && (buf_tag_ff == s1_btag);

   always_comb begin
      rsp_in     = '0;
      cache_fill = 1'b0;
      buf_fill   = 1'b0;
      miss_sum   = '0;
      case (s1_cmd_ff)
         CMD_CLEAR: begin
            rsp_in = '0;
         end
         CMD_ACCESS: begin
            if (s1_err) begin
               rsp_in.range_error = 1'b1;
            end else if (enable_ff) begin
               miss_sum = SUM_BITS'(latency_ff) + SUM_BITS'(update_ff)
                        + (SUM_BITS'(per_word_ff) << LINE_BITS);
               cache_fill = !cache_hit;
               rsp_in.hit = cache_hit;
            end else begin
               miss_sum = SUM_BITS'(latency_ff)
                        + (SUM_BITS'(per_word_ff) << BUF_BITS);
               buf_fill   = !buf_hit;
               rsp_in.hit = buf_hit;
            end
            if (!s1_err) begin
               if (rsp_in.hit) begin
                  rsp_in.cycles = HIT_CYCLES;
               end else if (miss_sum > SUM_BITS'(CYCLES_MAX)) begin
                  rsp_in.cycles = CYCLES_MAX;
               end else begin
                  rsp_in.cycles = miss_sum[CYC_BITS-1:0];
               end
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   assign tags_clear = (csr_we && csr_index == CSR_ENABLE)
                    || (s1_go && s1_cmd_ff == CMD_CLEAR);

   always_comb begin
      line_valid_in = line_valid_ff;
      buf_valid_in  = buf_valid_ff;
      buf_tag_in    = buf_tag_ff;
      if (tags_clear) begin
         line_valid_in = '0;
         buf_valid_in  = 1'b0;
      end else if (s1_go && cache_fill) begin
         line_valid_in[s1_line] = 1'b1;
      end else if (s1_go && buf_fill) begin
         buf_valid_in = 1'b1;
         buf_tag_in   = s1_btag;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s0_adv) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_tready);
   end

   // tag RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (s1_go && cache_fill) begin
         tag_mem[s1_line] <= s1_ctag;
      end
      if (s0_adv) begin
         tag_rd_ff <= tag_mem[req_line];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         latency_ff    <= 10'd10;
         update_ff     <= 8'd1;
         per_word_ff   <= 6'd1;
         line_valid_ff <= '0;
         buf_valid_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_ENABLE:   enable_ff   <= csr_wdata[0];
               CSR_LATENCY:  latency_ff  <= csr_wdata[9:0];
               CSR_UPDATE:   update_ff   <= csr_wdata[7:0];
               CSR_PER_WORD: per_word_ff <= csr_wdata[5:0];
               default: ;
            endcase
         end
         line_valid_ff <= line_valid_in;
         buf_valid_ff  <= buf_valid_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (s0_adv) begin
            fwd_ff <= s1_go && cache_fill && (s1_line == req_line);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      buf_tag_ff <= buf_tag_in;
      if (s0_adv) begin
         s1_cmd_ff  <= cmd_type'(req_tuser);
         s1_addr_ff <= req_tdata;
         fwd_tag_ff <= s1_ctag;
      end
      if (s1_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.range_error, rsp_ff.cycles, rsp_ff.hit};

   // compare stage only retires into a free or draining response register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_go |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten");

   // a line fill leaves that line valid
   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      (s1_go && cache_fill && !csr_we) |=> line_valid_ff[$past(s1_line)])
      else $error("filled line not valid");

   // a hit always reports HIT_CYCLES and never carries an error
   a_hit_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |-> (rsp_ff.cycles == HIT_CYCLES && !rsp_ff.range_error))
      else $error("bad hit response");

   // forwarding only applies to a request sitting in the compare stage
   a_fwd_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_ff) |-> s1_valid_ff)
      else $error("forward flag without request");

endmodule
